// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/ssfb_pkg.sv
package ssfb_pkg;

   localparam int NUM_DIGITS = 8;
   localparam int ROW_COUNT  = 8;
   localparam int ROW_IDX_W  = 3;

   localparam logic [7:0] CONTROL_RESET      = 8'h8A;
   localparam logic [7:0] CMD_AUTO_INCREMENT = 8'h40;
   localparam logic [7:0] CMD_START_ADDRESS  = 8'hC0;
   localparam logic [7:0] PAD_BYTE           = 8'h00;
   localparam logic [7:0] TABLE_LIMIT        = 8'd41;

   // Emission index: 19 bytes per update run.
   localparam int SEQ_IDX_W = 5;
   localparam logic [SEQ_IDX_W-1:0] IDX_CONTROL = 5'd0;
   localparam logic [SEQ_IDX_W-1:0] IDX_AUTO    = 5'd1;
   localparam logic [SEQ_IDX_W-1:0] IDX_START   = 5'd2;
   localparam logic [SEQ_IDX_W-1:0] IDX_ROWS    = 5'd3;
   localparam logic [SEQ_IDX_W-1:0] IDX_LAST    = 5'd18;

   typedef struct packed {
      logic [2:0] position;
      logic [7:0] symbol;
      logic       refresh;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
      logic       last;
   } rsp_type;

   // One bit-insert into the transposed row buffer.
   typedef struct packed {
      logic                 en;
      logic [ROW_IDX_W-1:0] row;
      logic [2:0]           col;
      logic                 seg_bit;
   } row_write_type;

   function automatic logic [7:0] glyph(input logic [7:0] sym);
      logic [7:0] pat;
      case (sym)
         8'd0:  pat = 8'h3F;  8'd1:  pat = 8'h06;  8'd2:  pat = 8'h5B;  8'd3:  pat = 8'h4F;
         8'd4:  pat = 8'h66;  8'd5:  pat = 8'h6D;  8'd6:  pat = 8'h7D;  8'd7:  pat = 8'h07;
         8'd8:  pat = 8'h7F;  8'd9:  pat = 8'h6F;  8'd10: pat = 8'h77;  8'd11: pat = 8'h7C;
         8'd12: pat = 8'h39;  8'd13: pat = 8'h5E;  8'd14: pat = 8'h79;  8'd15: pat = 8'h71;
         8'd16: pat = 8'hBF;  8'd17: pat = 8'h86;  8'd18: pat = 8'hDB;  8'd19: pat = 8'hCF;
         8'd20: pat = 8'hE6;  8'd21: pat = 8'hED;  8'd22: pat = 8'hFD;  8'd23: pat = 8'h87;
         8'd24: pat = 8'hFF;  8'd25: pat = 8'hEF;  8'd26: pat = 8'hF7;  8'd27: pat = 8'hFC;
         8'd28: pat = 8'hB9;  8'd29: pat = 8'hDE;  8'd30: pat = 8'hF9;  8'd31: pat = 8'hF1;
         8'd32: pat = 8'h01;  8'd33: pat = 8'h02;  8'd34: pat = 8'h04;  8'd35: pat = 8'h08;
         8'd36: pat = 8'h10;  8'd37: pat = 8'h20;  8'd38: pat = 8'h40;  8'd39: pat = 8'h80;
         8'd40: pat = 8'h00;
         default: pat = sym;  // raw segment pattern
      endcase
      return pat;
   endfunction

endpackage

// File: rtl/ssfb_row_buffer.sv
module ssfb_row_buffer (
   input  logic                          clock,
   input  logic                          reset,
   input  ssfb_pkg::row_write_type       wr,
   input  logic [ssfb_pkg::ROW_IDX_W-1:0] rd_row,
   output logic [7:0]                    rd_data
);
   import ssfb_pkg::*;

   logic [7:0] rows_ff [ROW_COUNT];

   // Shared bit-insert: one row updated per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROW_COUNT; k++) begin
            rows_ff[k] <= 8'(8'h80 >> k);
         end
      end else if (wr.en) begin
         rows_ff[wr.row][wr.col] <= wr.seg_bit;
      end
   end

   assign rd_data = rows_ff[rd_row];

endmodule

// File: rtl/seven_segment_frame_builder_unit.sv
// Seven-segment frame builder.
// req channel (req_valid / req_stall / req): one request rewrites the segment
// column of one digit position from a glyph code or a raw pattern; with
// refresh set it then emits the 19-byte display update on the rsp channel.
// rsp channel (rsp_valid / rsp_stall / rsp): data_byte, frame_end, last.
// csr channel (csr_valid / csr_ready / csr_data): display control byte,
// always ready; the user must write it only while the block is idle; not enforced.
// Timing: a request is accepted when req_valid is high and req_stall low.
// The bit-insert unit then walks the 8 segment rows, one row per cycle.
// With refresh, the byte sequencer follows with 19 bytes, one per cycle
// into the output register while rsp is not stalled; row bytes come from
// the stored rows, alternating with pads. req_stall stays high through
// the row walk and, with refresh, until the last byte is loaded; the
// emit state follows the last row write and then loads the first byte.
// A rsp_stall on a valid byte freezes the output register and sequencer in place; no
// byte is lost or repeated. The next request may be accepted while the
// final byte still waits in the output register.
// Reset (synchronous, active high) loads row k with 0x80 >> k, sets the
// control byte to 0x8A and returns the sequencer to idle.
`include "assert_macros.svh"

module seven_segment_frame_builder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ssfb_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ssfb_pkg::rsp_type rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import ssfb_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WRITE = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [ROW_IDX_W-1:0] row_ff, row_in;       // bit-insert row counter
   logic [SEQ_IDX_W-1:0] idx_ff, idx_in;       // byte sequencer index
   logic [7:0]           pattern_ff, pattern_in;
   logic [2:0]           col_ff, col_in;
   logic                 refresh_ff, refresh_in;
   logic [7:0]           control_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   row_write_type        wr;
   logic [ROW_IDX_W-1:0] rd_row;
   logic [7:0]           rd_data;
   logic [SEQ_IDX_W-1:0] rel_idx;
   logic                 accept, load;

   // ---- configuration ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= CONTROL_RESET;
      end else if (csr_valid && csr_ready) begin
         control_ff <= csr_data;
      end
   end

   // ---- handshakes ----
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // ---- row buffer ----
   assign wr.en      = (state_ff == ST_WRITE);
   assign wr.row     = row_ff;
   assign wr.col     = col_ff;
   assign wr.seg_bit = pattern_ff[row_ff];

   // Row bytes and pads alternate after the start-address byte.
   assign rel_idx = idx_ff - IDX_ROWS;
   assign rd_row  = rel_idx[ROW_IDX_W:1];

   ssfb_row_buffer u_rows (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   // ---- byte selection ----
   always_comb begin
      rsp_in.frame_end = 1'b0;
      rsp_in.last      = 1'b0;
      case (idx_ff)
         IDX_CONTROL: begin
            rsp_in.data_byte = control_ff;
            rsp_in.frame_end = 1'b1;
         end
         IDX_AUTO: begin
            rsp_in.data_byte = CMD_AUTO_INCREMENT;
            rsp_in.frame_end = 1'b1;
         end
         IDX_START: begin
            rsp_in.data_byte = CMD_START_ADDRESS;
         end
         default: begin
            rsp_in.data_byte = rel_idx[0] ? PAD_BYTE : rd_data;
            rsp_in.frame_end = (idx_ff == IDX_LAST);
            rsp_in.last      = (idx_ff == IDX_LAST);
         end
      endcase
   end

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      pattern_in   = pattern_ff;
      col_in       = col_ff;
      refresh_in   = refresh_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // Positions past the last digit are dropped.
            if (accept && ({1'b0, req.position} < 4'(NUM_DIGITS))) begin
               pattern_in = (req.symbol < TABLE_LIMIT) ? glyph(req.symbol) : req.symbol;
               col_in     = req.position;
               refresh_in = req.refresh;
               row_in     = '0;
               state_in   = ST_WRITE;
            end
         end
         ST_WRITE: begin
            row_in = row_ff + 1'b1;
            if (row_ff == ROW_IDX_W'(ROW_COUNT - 1)) begin
               idx_in   = IDX_CONTROL;
               state_in = refresh_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
      col_ff     <= col_in;
      refresh_ff <= refresh_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // ---- assertions ----
   // A waiting final byte may overlap the next request; the next run then
   // holds at its first byte until the final byte is taken.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_stall)
   `ASSERT_IMPLIES(a_emit_idx_range, clock, reset, state_ff == ST_EMIT, idx_ff <= IDX_LAST)
   `ASSERT_IMPLIES(a_last_ends_run, clock, reset, rsp_valid && rsp.last,
                   (state_ff != ST_EMIT) || (idx_ff == IDX_CONTROL))

endmodule

// File: test/tb_seven_segment_frame_builder_unit.sv
module tb_seven_segment_frame_builder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ssfb_pkg::*;

   // Generous ceiling: every request refreshing, every byte waiting out long
   // stalls and long sender gaps still finishes far below this.
   localparam int CYCLE_LIMIT   = 1000000;
   // Quiet time after the last byte: covers the row walk of a request
   // without refresh, so the block is idle before a csr write.
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 49;
   localparam logic [7:0] CONTROL_LOW  = 8'd128;
   localparam logic [7:0] CONTROL_HIGH = 8'd143;

   // Idle modes, cycled through the random phases.
   typedef enum int {
      MODE_NO_IDLE,
      MODE_SENDER_IDLE,
      MODE_RECEIVER_STALL,
      MODE_BOTH_IDLE
   } idle_mode_type;

   // ---------------------------------------------------------------------
   // Scoreboard: mirrors the transposed row buffer and the control byte,
   // builds the 19-byte update for each refreshing request and checks the
   // bytes that come out against it in order.
   // ---------------------------------------------------------------------
   class byte_scoreboard;
      localparam logic [0:15][7:0] HEX_GLYPHS = {
         8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
         8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
      };

      logic [7:0] seg_rows [ROW_COUNT];
      logic [7:0] control;
      rsp_type    update_bytes [$];
      int         errors;
      int         requests;
      int         refreshes;
      int         bytes_checked;

      function new();
         for (int k = 0; k < ROW_COUNT; k++) seg_rows[k] = 8'h80 >> k;
         control       = CONTROL_RESET;
         errors        = 0;
         requests      = 0;
         refreshes     = 0;
         bytes_checked = 0;
      endfunction

      // 0..15 hex, 16..31 hex plus dot, 32..39 one segment, 40 blank,
      // anything else is the raw pattern.
      function logic [7:0] seg_pattern(input logic [7:0] sym);
         if (sym < 8'd16) return HEX_GLYPHS[sym[3:0]];
         if (sym < 8'd32) return HEX_GLYPHS[sym[3:0]] | 8'h80;
         if (sym < 8'd40) return 8'h01 << (sym - 8'd32);
         if (sym < TABLE_LIMIT) return 8'h00;
         return sym;
      endfunction

      function void set_control(input logic [7:0] value);
         control = value;
      endfunction

      function void push_byte(input logic [7:0] data, input logic fe, input logic lst);
         rsp_type b;
         b.data_byte = data;
         b.frame_end = fe;
         b.last      = lst;
         update_bytes.push_back(b);
      endfunction

      function void note_request(input req_type r);
         logic [7:0] pattern;
         requests++;
         // positions past the last digit write nothing and send nothing
         if (int'(r.position) >= NUM_DIGITS) return;
         pattern = seg_pattern(r.symbol);
         for (int k = 0; k < ROW_COUNT; k++) seg_rows[k][r.position] = pattern[k];
         if (!r.refresh) return;
         refreshes++;
         push_byte(control, 1'b1, 1'b0);
         push_byte(CMD_AUTO_INCREMENT, 1'b1, 1'b0);
         push_byte(CMD_START_ADDRESS, 1'b0, 1'b0);
         for (int k = 0; k < ROW_COUNT; k++) begin
            push_byte(seg_rows[k], 1'b0, 1'b0);
            push_byte(PAD_BYTE, k == ROW_COUNT - 1, k == ROW_COUNT - 1);
         end
      endfunction

      function void report(input string field, input logic [7:0] want, input logic [7:0] got);
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
      endfunction

      function void check_byte(input rsp_type got);
         rsp_type want;
         if (update_bytes.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: unexpected byte: expected none actual %h fe=%b last=%b",
                        $time, got.data_byte, got.frame_end, got.last);
            return;
         end
         want = update_bytes.pop_front();
         bytes_checked++;
         if (got.data_byte !== want.data_byte) report("data_byte", want.data_byte, got.data_byte);
         if (got.frame_end !== want.frame_end)
            report("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
         if (got.last !== want.last) report("last", {7'd0, want.last}, {7'd0, got.last});
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------
   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   seven_segment_frame_builder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   byte_scoreboard sb;
   int             sender_idle_pct;
   int             stall_pct;
   int             cycle_count;

   // all inputs known from time zero, reset held from the start
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req             = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      sender_idle_pct = 0;
      stall_pct       = 0;
      cycle_count     = 0;
      sb              = new();
   end

   always #5 clock = ~clock;

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d update bytes still pending", $time,
                  sb.update_bytes.size());
         $display("seven_segment_frame_builder_unit test failed");
         $finish;
      end
   end

   // Receiver back-pressure: one fresh draw per cycle, never during reset.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   // Monitors sample pre-edge values, so they see exactly what the DUT saw.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_byte(rsp);
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Present one request, after a random idle gap, and hold it until taken.
   // With no gap valid stays high across back-to-back requests.
   task automatic send_request(input req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send(input logic [2:0] pos, input logic [7:0] sym, input logic refr);
      req_type item;
      item.position = pos;
      item.symbol   = sym;
      item.refresh  = refr;
      send_request(item);
   endtask

   // Let every queued byte drain, then allow the row walk to finish.
   // It first waits on the clock, so the monitor has logged the last accepted request.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.update_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_control(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_control(value);
      csr_valid <= 1'b0;
   endtask

   // Random content; table codes, raw patterns and the table boundary
   // all get a fair share. Refresh about two times in five.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.position = 3'($urandom_range(0, NUM_DIGITS - 1));
      pick       = $urandom_range(0, 99);
      if (pick < 45)      r.symbol = 8'($urandom_range(0, 40));
      else if (pick < 90) r.symbol = 8'($urandom_range(41, 255));
      else                r.symbol = 8'($urandom_range(39, 42));
      r.refresh = ($urandom_range(0, 99) < 40);
      return r;
   endfunction

   function automatic void set_idle_mode(input idle_mode_type mode);
      case (mode)
         MODE_NO_IDLE: begin
            sender_idle_pct = 0;
            stall_pct       = 0;
         end
         MODE_SENDER_IDLE: begin
            sender_idle_pct = 79;
            stall_pct       = 0;
         end
         MODE_RECEIVER_STALL: begin
            sender_idle_pct = 0;
            stall_pct       = 79;
         end
         default: begin
            sender_idle_pct = 20;
            stall_pct       = 20;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [7:0] ctrl_value;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset control byte and reset rows on the first refresh,
      // both position extremes, table edges (hex, hex with dot, single
      // segments, blank), first raw code and raw extremes, refresh on/off.
      // A position past the last digit cannot be encoded with 8 digits.
      set_idle_mode(MODE_NO_IDLE);
      send(3'd0, 8'd0,   1'b1);
      send(3'd7, 8'd255, 1'b1);
      send(3'd1, 8'd15,  1'b0);
      send(3'd2, 8'd16,  1'b0);
      send(3'd3, 8'd31,  1'b1);
      send(3'd4, 8'd32,  1'b0);
      send(3'd5, 8'd39,  1'b0);
      send(3'd6, 8'd40,  1'b1);
      send(3'd7, 8'd41,  1'b0);
      send(3'd0, 8'hAA,  1'b1);
      send(3'd3, 8'h55,  1'b0);
      send(3'd5, 8'h80,  1'b1);
      for (int d = 0; d < NUM_DIGITS; d++)
         send(d[2:0], 8'd33 + d[7:0], d == NUM_DIGITS - 1);
      send(3'd2, 8'hFE,  1'b1);
      send(3'd6, 8'd0,   1'b0);
      wait_idle();

      // Random phases: each under a new control byte and an idle mode.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       ctrl_value = CONTROL_HIGH;
            1:       ctrl_value = CONTROL_LOW;
            2:       ctrl_value = CONTROL_RESET;
            default: ctrl_value = 8'($urandom_range(CONTROL_LOW, CONTROL_HIGH));
         endcase
         write_control(ctrl_value);
         set_idle_mode(idle_mode_type'(ph % 4));
         for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
         wait_idle();
      end

      $display("Run covered %0d requests, %0d refreshes, %0d update bytes checked,",
               sb.requests, sb.refreshes, sb.bytes_checked);
      $display("under four idle/stall modes and %0d control byte settings.", PHASE_COUNT + 1);
      if (sb.errors == 0 && sb.update_bytes.size() == 0) begin
         $display("seven_segment_frame_builder_unit test passed");
      end else begin
         $display("seven_segment_frame_builder_unit test failed");
      end
      $finish;
   end

endmodule
